/* design/arpc_pkg.sv */
// Package for the IPv4-to-MAC binding cache: field widths, result codes,
// the cache entry layout and the sequencer state type.
// Used by arp_cache_ipv4 and by its port checker.
package arpc_pkg;

    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int TIME_W   = 48;
    localparam int AGE_W    = 32;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;

    // Default stale limit: one hour in milliseconds.
    localparam logic [AGE_W-1:0] MAX_AGE_RESET = AGE_W'(60 * 60 * 1000);

    // Request kinds carried on the input tuser.
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    // Result codes carried on the output tuser.
    localparam logic [STATUS_W-1:0] ST_HIT       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STALE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 2'd3;

    // One cache entry; a zero timestamp marks a free slot.
    typedef struct packed {
        logic [TIME_W-1:0] etime;
        logic [MAC_W-1:0]  mac;
        logic [IP_W-1:0]   ip;
    } t_entry;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

endpackage

/* design/arp_cache_ipv4.sv */
// IPv4-to-MAC binding cache with ageing, built around one entry memory.
// Depends on arpc_pkg.
//
// The cache holds ENTRIES bindings in a memory with one write port and one
// registered read port. One request is in work at a time, and each is a scan
// that reads one entry per cycle. A lookup walks upward from slot 0 and stops
// at the first valid match, or answers a miss after the last slot. An update
// first reads slot 0 (the seed for the oldest-entry search), then walks down
// from the top, stopping early when it meets a matching entry, and ends with
// a write-back. After reset the block runs a clearing pass over every entry
// with the input ready low; the max_age register can be written at any time.
// A finished result waits in an output register, and the next request is
// taken while it does.
module arp_cache_ipv4 #(
    parameter int ENTRIES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration: max_age in milliseconds.
    input  logic         i_cfg_wr_en,
    input  logic [31:0]  i_cfg_wr_data,
    // Request stream.
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,   // ip_addr[31:0], mac_in[79:32], time_now[127:80]
    input  logic         i_s_tuser,   // func[0]
    // Result stream.
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [55:0]  o_m_tdata,   // mac_out[47:0], slot[53:48], zero pad[55:54]
    output logic [1:0]   o_m_tuser    // status[1:0]
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    // Configuration register.
    logic [arpc_pkg::AGE_W-1:0] r_max_age;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age <= arpc_pkg::MAX_AGE_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_age <= i_cfg_wr_data;
        end
    end

    // Control state.
    arpc_pkg::t_state r_state;
    logic [IW-1:0]    r_clr_idx;
    logic [IW-1:0]    r_iss_idx;
    logic             r_iss_first;
    logic             r_iss_done;
    logic             r_dv;
    logic             r_ovalid;

    // Request and scan payload.
    logic                          r_func;
    logic [arpc_pkg::IP_W-1:0]     r_ip;
    logic [arpc_pkg::MAC_W-1:0]    r_mac;
    logic [arpc_pkg::TIME_W-1:0]   r_now;
    logic [IW-1:0]                 r_didx;
    logic                          r_dfirst;
    logic [IW-1:0]                 r_old_idx;
    logic [arpc_pkg::TIME_W-1:0]   r_old_time;
    logic                          r_free_found;
    logic [IW-1:0]                 r_free_idx;
    logic [IW-1:0]                 r_tgt;
    logic [arpc_pkg::STATUS_W-1:0] r_status;
    logic [arpc_pkg::MAC_W-1:0]    r_mac_res;
    logic [arpc_pkg::SLOT_W-1:0]   r_slot_res;
    logic [arpc_pkg::STATUS_W-1:0] r_o_status;
    logic [arpc_pkg::MAC_W-1:0]    r_o_mac;
    logic [arpc_pkg::SLOT_W-1:0]   r_o_slot;

    // Entry memory.
    arpc_pkg::t_entry r_mem [ENTRIES];
    arpc_pkg::t_entry r_rd_data;

    logic             in_xfer;
    logic             out_free;
    logic             rd_en;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    arpc_pkg::t_entry wr_data;

    assign in_xfer  = i_s_tvalid && o_s_tready;
    assign out_free = !r_ovalid || i_m_tready;
    assign rd_en    = (r_state == arpc_pkg::S_SCAN) && !r_iss_done;

    // The write port serves the clearing pass and the update write-back.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr_idx;
        wr_data = '0;
        if (r_state == arpc_pkg::S_CLEAR) begin
            wr_en = 1'b1;
        end else if (r_state == arpc_pkg::S_WRITE) begin
            wr_en         = 1'b1;
            wr_addr       = r_tgt;
            wr_data.ip    = r_ip;
            wr_data.mac   = r_mac;
            wr_data.etime = r_now;
        end
    end

    // Reads and writes never overlap on an entry: the write-back comes only
    // after the scan has stopped issuing reads.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_iss_idx];
        end
    end

    // Per-entry tests on the data just read.
    logic                        hit_match;
    logic [arpc_pkg::TIME_W-1:0] age;
    logic                        stale;

    assign hit_match = (r_rd_data.etime != '0) && (r_rd_data.ip == r_ip);
    assign age       = (r_now >= r_rd_data.etime) ? (r_now - r_rd_data.etime) : '0;
    assign stale     = age > arpc_pkg::TIME_W'(r_max_age);

    // Running oldest and free candidates for an update, including this entry.
    logic [IW-1:0]               c_old_idx;
    logic [arpc_pkg::TIME_W-1:0] c_old_time;
    logic                        c_free_found;
    logic [IW-1:0]               c_free_idx;

    always_comb begin
        c_old_idx    = r_old_idx;
        c_old_time   = r_old_time;
        c_free_found = r_free_found;
        c_free_idx   = r_free_idx;
        if (r_dfirst) begin
            c_old_idx  = '0;
            c_old_time = r_rd_data.etime;
        end else begin
            if (r_old_time > r_rd_data.etime) begin
                c_old_idx  = r_didx;
                c_old_time = r_rd_data.etime;
            end
            if ((r_rd_data.etime == '0) && !r_free_found) begin
                c_free_found = 1'b1;
                c_free_idx   = r_didx;
            end
        end
    end

    // Sequencer and read-address generator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= arpc_pkg::S_CLEAR;
            r_clr_idx   <= '0;
            r_iss_idx   <= '0;
            r_iss_first <= 1'b0;
            r_iss_done  <= 1'b0;
            r_dv        <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            // Read issue: one entry per cycle while the scan runs.
            r_dv <= rd_en;
            if (rd_en) begin
                if (r_func == arpc_pkg::FUNC_UPDATE) begin
                    if (r_iss_first) begin
                        r_iss_idx   <= LAST;
                        r_iss_first <= 1'b0;
                    end else if (r_iss_idx == '0) begin
                        r_iss_done <= 1'b1;
                    end else begin
                        r_iss_idx <= r_iss_idx - 1'b1;
                    end
                end else begin
                    if (r_iss_idx == LAST) begin
                        r_iss_done <= 1'b1;
                    end else begin
                        r_iss_idx <= r_iss_idx + 1'b1;
                    end
                end
            end

            // A waiting result leaves on its output transfer; a finished
            // result moves in when the output register is free.
            if ((r_state == arpc_pkg::S_DONE) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                arpc_pkg::S_CLEAR: begin
                    if (r_clr_idx == LAST) begin
                        r_state <= arpc_pkg::S_IDLE;
                    end else begin
                        r_clr_idx <= r_clr_idx + 1'b1;
                    end
                end
                arpc_pkg::S_IDLE: begin
                    if (in_xfer) begin
                        r_state     <= arpc_pkg::S_SCAN;
                        r_iss_idx   <= '0;
                        r_iss_first <= i_s_tuser;
                        r_iss_done  <= 1'b0;
                    end
                end
                arpc_pkg::S_SCAN: begin
                    if (r_dv) begin
                        if (r_func == arpc_pkg::FUNC_UPDATE) begin
                            if (!r_dfirst && (hit_match || (r_didx == '0))) begin
                                r_state <= arpc_pkg::S_WRITE;
                            end
                        end else if (hit_match || (r_didx == LAST)) begin
                            r_state <= arpc_pkg::S_DONE;
                        end
                    end
                end
                arpc_pkg::S_WRITE: begin
                    r_state <= arpc_pkg::S_DONE;
                end
                arpc_pkg::S_DONE: begin
                    if (out_free) begin
                        r_state <= arpc_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= arpc_pkg::S_IDLE;
                end
            endcase
        end
    end

    // Payload registers: request capture, scan candidates and results.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_func       <= i_s_tuser;
            r_ip         <= i_s_tdata[31:0];
            r_mac        <= i_s_tdata[79:32];
            r_now        <= i_s_tdata[127:80];
            r_free_found <= 1'b0;
        end

        if (rd_en) begin
            r_didx   <= r_iss_idx;
            r_dfirst <= r_iss_first;
        end

        // Judge the entry that arrived from the memory.
        if ((r_state == arpc_pkg::S_SCAN) && r_dv) begin
            if (r_func == arpc_pkg::FUNC_UPDATE) begin
                r_old_idx    <= c_old_idx;
                r_old_time   <= c_old_time;
                r_free_found <= c_free_found;
                r_free_idx   <= c_free_idx;
                if (!r_dfirst) begin
                    if (hit_match) begin
                        r_tgt <= r_didx;
                    end else if (r_didx == '0) begin
                        r_tgt <= c_free_found ? c_free_idx : c_old_idx;
                    end
                end
            end else if (hit_match) begin
                r_status   <= stale ? arpc_pkg::ST_STALE : arpc_pkg::ST_HIT;
                r_mac_res  <= stale ? '0 : r_rd_data.mac;
                r_slot_res <= arpc_pkg::SLOT_W'(r_didx);
            end else if (r_didx == LAST) begin
                r_status   <= arpc_pkg::ST_NOT_FOUND;
                r_mac_res  <= '0;
                r_slot_res <= '0;
            end
        end

        // Update result, formed with the write-back.
        if (r_state == arpc_pkg::S_WRITE) begin
            r_status   <= arpc_pkg::ST_UPDATED;
            r_mac_res  <= '0;
            r_slot_res <= arpc_pkg::SLOT_W'(r_tgt);
        end

        // Move the result into the output register.
        if ((r_state == arpc_pkg::S_DONE) && out_free) begin
            r_o_status <= r_status;
            r_o_mac    <= r_mac_res;
            r_o_slot   <= r_slot_res;
        end
    end

    assign o_s_tready = (r_state == arpc_pkg::S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {2'b00, r_o_slot, r_o_mac};
    assign o_m_tuser  = r_o_status;

endmodule

/* design/arpc_checker.sv */
// Port-level checker for arp_cache_ipv4, with the bind that attaches it.
// Depends on arpc_pkg.
module arpc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [55:0]  o_m_tdata,
    input logic [1:0]   o_m_tuser
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result withdrawn before its transfer");

    // A stalled result keeps its data.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // Only a hit carries a MAC address.
    a_mac_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != arpc_pkg::ST_HIT) |-> (o_m_tdata[47:0] == '0))
        else $error("MAC reported on a result that is not a hit");

    // A miss reports slot zero.
    a_miss_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == arpc_pkg::ST_NOT_FOUND) |-> (o_m_tdata[53:48] == '0))
        else $error("nonzero slot on a miss");

    // A request starts a scan, so ready drops after each transfer.
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while a scan is running");

endmodule

bind arp_cache_ipv4 arpc_checker u_arpc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

/* bench/arp_cache_ipv4_tb.sv */
// Self-checking bench for arp_cache_ipv4: random lookups and updates against a
// cycle-free model of the binding cache, with idling and stalls on both streams.
// Depends on arpc_pkg and the arp_cache_ipv4 RTL.
`timescale 1ns / 1ps

module arp_cache_ipv4_tb;

    localparam int CACHE_DEPTH    = 64;
    localparam int POOL_SIZE      = 96;
    localparam int LONG_HOLD      = 600;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;
    localparam logic [63:0] TIME_MASK = {16'b0, {arpc_pkg::TIME_W{1'b1}}};
    localparam logic [arpc_pkg::TIME_W-1:0] RESET_AGE =
        arpc_pkg::TIME_W'(arpc_pkg::MAX_AGE_RESET);

    typedef struct packed {
        logic                        func;
        logic [arpc_pkg::IP_W-1:0]   ip;
        logic [arpc_pkg::MAC_W-1:0]  mac;
        logic [arpc_pkg::TIME_W-1:0] now;
    } t_request;

    typedef struct packed {
        logic [arpc_pkg::STATUS_W-1:0] status;
        logic [arpc_pkg::MAC_W-1:0]    mac;
        logic [arpc_pkg::SLOT_W-1:0]   slot;
    } t_binding;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         i_cfg_wr_en   = 1'b0;
    logic [31:0]  i_cfg_wr_data = '0;
    logic         i_s_tvalid    = 1'b0;
    logic         o_s_tready;
    logic [127:0] i_s_tdata     = '0;   // ip_addr[31:0], mac_in[79:32], time_now[127:80]
    logic         i_s_tuser     = 1'b0; // func[0]
    logic         o_m_tvalid;
    logic         i_m_tready    = 1'b0;
    logic [55:0]  o_m_tdata;            // mac_out[47:0], slot[53:48], zero pad[55:54]
    logic [1:0]   o_m_tuser;            // status[1:0]

    // Predicted cache contents and stale limit.
    logic [arpc_pkg::IP_W-1:0]   cache_ip   [CACHE_DEPTH];
    logic [arpc_pkg::MAC_W-1:0]  cache_mac  [CACHE_DEPTH];
    logic [arpc_pkg::TIME_W-1:0] cache_time [CACHE_DEPTH];
    logic [arpc_pkg::AGE_W-1:0]  age_limit;

    t_request req_q[$];
    t_binding answer_q[$];
    t_request cur_req;

    logic [arpc_pkg::IP_W-1:0] ip_pool [POOL_SIZE];
    logic [63:0]     clock_ms;
    bit              src_idle_on = 1'b1;
    bit              snk_idle_on = 1'b1;
    int              holds_asked = 0;
    int              err_cnt     = 0;
    int              n_sent      = 0;
    int              n_checked   = 0;
    int              n_hit       = 0;
    int              n_stale     = 0;
    int              n_miss      = 0;
    int              n_update    = 0;
    int              n_limits    = 0;

    arp_cache_ipv4 #(
        .ENTRIES(CACHE_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser)
    );

    // 125 MHz clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Computes the answer to one request and applies its effect on the cache.
    function automatic t_binding resolve_request(t_request rq);
        t_binding                    res;
        logic [arpc_pkg::TIME_W-1:0] age;
        int                          i;
        int                          found;
        int                          vacant;
        int                          oldest;
        int                          target;
        res    = '0;
        found  = -1;
        vacant = -1;
        oldest = 0;
        if (rq.func == arpc_pkg::FUNC_LOOKUP) begin
            // Upward scan; the first valid match wins.
            for (i = 0; i < CACHE_DEPTH; i++) begin
                if (found < 0 && cache_time[i] != '0 && cache_ip[i] == rq.ip)
                    found = i;
            end
            res.status = arpc_pkg::ST_NOT_FOUND;
            if (found >= 0) begin
                age = (rq.now >= cache_time[found]) ? rq.now - cache_time[found] : '0;
                if (age > arpc_pkg::TIME_W'(age_limit)) begin
                    res.status = arpc_pkg::ST_STALE;
                end else begin
                    res.status = arpc_pkg::ST_HIT;
                    res.mac    = cache_mac[found];
                end
                res.slot = found[arpc_pkg::SLOT_W-1:0];
            end
        end else begin
            // Downward scan; the oldest candidate only sees slots visited up to a match.
            for (i = CACHE_DEPTH - 1; i >= 0; i--) begin
                if (found < 0) begin
                    if (cache_time[oldest] > cache_time[i])
                        oldest = i;
                    if (cache_time[i] != '0 && cache_ip[i] == rq.ip)
                        found = i;
                    else if (cache_time[i] == '0 && vacant < 0)
                        vacant = i;
                end
            end
            if (found >= 0) begin
                target = found;
            end else begin
                target = (vacant >= 0) ? vacant : oldest;
                cache_ip[target] = rq.ip;
            end
            cache_mac[target]  = rq.mac;
            cache_time[target] = rq.now;
            res.status = arpc_pkg::ST_UPDATED;
            res.slot   = target[arpc_pkg::SLOT_W-1:0];
        end
        return res;
    endfunction

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Advances the running time and returns a stamp for the next request. Some
    // stamps jump past the stale limit, a few run backwards.
    function automatic logic [arpc_pkg::TIME_W-1:0] next_stamp();
        logic [63:0]                 advance;
        logic [arpc_pkg::TIME_W-1:0] t;
        int                          r;
        r = $urandom_range(0, 99);
        advance = '0;
        if (r < 62) begin
            advance = 64'($urandom_range(0, 2000));
        end else if (r < 80) begin
            advance = 64'($urandom_range(0, age_limit)) + 64'($urandom_range(0, age_limit));
        end else if (r < 88) begin
            advance = 64'(age_limit) + 64'($urandom_range(1, 1000));
        end else if (r < 95) begin
            t = clock_ms[arpc_pkg::TIME_W-1:0] - arpc_pkg::TIME_W'($urandom_range(1, 5000));
            return (t == '0) ? arpc_pkg::TIME_W'(1) : t;
        end
        clock_ms = (clock_ms + advance) & TIME_MASK;
        if (clock_ms == 0)
            clock_ms = 1;
        return clock_ms[arpc_pkg::TIME_W-1:0];
    endfunction

    function automatic t_request random_request(int span);
        t_request rq;
        rq.func = ($urandom_range(0, 99) < 45) ? arpc_pkg::FUNC_UPDATE : arpc_pkg::FUNC_LOOKUP;
        rq.ip   = ($urandom_range(0, 9) == 0) ? arpc_pkg::IP_W'($urandom)
                                               : ip_pool[$urandom_range(0, span - 1)];
        rq.mac  = arpc_pkg::MAC_W'({$urandom, $urandom});
        rq.now  = next_stamp();
        return rq;
    endfunction

    task automatic queue_request(logic func, logic [arpc_pkg::IP_W-1:0] ip,
                                 logic [arpc_pkg::MAC_W-1:0] mac,
                                 logic [arpc_pkg::TIME_W-1:0] now);
        t_request rq;
        rq.func = func;
        rq.ip   = ip;
        rq.mac  = mac;
        rq.now  = now;
        req_q.push_back(rq);
    endtask

    task automatic queue_random(int count, int span);
        int k;
        for (k = 0; k < count; k++)
            req_q.push_back(random_request(span));
    endtask

    // Returns once every request has been sent and answered. The check runs at
    // the falling edge, after every process of the rising edge has settled.
    task automatic wait_drained();
        while (req_q.size() != 0 || i_s_tvalid || answer_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Writes the stale limit; called only while the cache is idle.
    task automatic set_age_limit(logic [arpc_pkg::AGE_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        age_limit = value;
        n_limits++;
    endtask

    task automatic flag_error(string msg);
        err_cnt++;
        if (err_cnt <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
            flag_error($sformatf("result %0d: %s mismatch, expected 0x%0h, got 0x%0h",
                                 n_checked, name, want, got));
    endtask

    // Request driver: holds each transfer until accepted, then idles at random.
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                answer_q.push_back(resolve_request(cur_req));
                n_sent++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (req_q.size() != 0) begin
                    cur_req = req_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {cur_req.now, cur_req.mac, cur_req.ip};
                    i_s_tuser  <= cur_req.func;
                    src_gap = src_idle_on ? draw_gap() : 0;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result ready: random gaps, plus a long hold-off whenever one is asked for.
    int snk_gap   = 0;
    int hold_left = 0;
    int holds_run = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            snk_gap = 0;
        end else if (holds_run != holds_asked) begin
            holds_run++;
            hold_left = LONG_HOLD;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            snk_gap = snk_idle_on ? draw_gap() : 0;
        end
    end

    // Result monitor: each transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_binding want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (answer_q.size() == 0) begin
                flag_error($sformatf("unexpected result: status %0d, tdata 0x%0h",
                                     o_m_tuser, o_m_tdata));
            end else begin
                want = answer_q.pop_front();
                compare_field("status", 64'(want.status), 64'(o_m_tuser));
                compare_field("mac_out", 64'(want.mac), 64'(o_m_tdata[arpc_pkg::MAC_W-1:0]));
                compare_field("slot", 64'(want.slot),
                              64'(o_m_tdata[arpc_pkg::MAC_W +: arpc_pkg::SLOT_W]));
                compare_field("pad", '0,
                              64'(o_m_tdata[55:arpc_pkg::MAC_W+arpc_pkg::SLOT_W]));
                case (want.status)
                    arpc_pkg::ST_HIT:       n_hit++;
                    arpc_pkg::ST_STALE:     n_stale++;
                    arpc_pkg::ST_NOT_FOUND: n_miss++;
                    default:                n_update++;
                endcase
                n_checked++;
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, answer_q.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // Stimulus sequence, phase by phase; the stale limit changes between phases.
    initial begin
        int k;
        for (k = 0; k < CACHE_DEPTH; k++) begin
            cache_ip[k]   = '0;
            cache_mac[k]  = '0;
            cache_time[k] = '0;
        end
        age_limit = arpc_pkg::MAX_AGE_RESET;
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        for (k = 2; k < POOL_SIZE; k++)
            ip_pool[k] = arpc_pkg::IP_W'($urandom);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default limit: free slots never match, exact-limit age, time going backwards.
        queue_request(arpc_pkg::FUNC_LOOKUP, ip_pool[0], '1, 48'd1);
        queue_request(arpc_pkg::FUNC_LOOKUP, ip_pool[1], '0, 48'd1);
        queue_request(arpc_pkg::FUNC_UPDATE, ip_pool[0], '1, 48'd1);
        queue_request(arpc_pkg::FUNC_UPDATE, ip_pool[1], '0, 48'd2);
        queue_request(arpc_pkg::FUNC_LOOKUP, ip_pool[0], '0, 48'd3);
        queue_request(arpc_pkg::FUNC_UPDATE, ip_pool[0], 48'h1234_5678_9ABC, 48'd10);
        queue_request(arpc_pkg::FUNC_LOOKUP, ip_pool[0], '0, RESET_AGE + 48'd10);
        queue_request(arpc_pkg::FUNC_LOOKUP, ip_pool[0], '0, RESET_AGE + 48'd11);
        queue_request(arpc_pkg::FUNC_LOOKUP, ip_pool[0], '0, 48'd5);
        queue_request(arpc_pkg::FUNC_LOOKUP, ip_pool[1], '0, '1);
        queue_request(arpc_pkg::FUNC_UPDATE, ip_pool[4], 48'hA5A5_5A5A_F00F, '1);
        queue_request(arpc_pkg::FUNC_LOOKUP, ip_pool[4], '0, 48'd1);
        queue_request(arpc_pkg::FUNC_LOOKUP, ip_pool[5], '0, 48'd7);
        wait_drained();

        // Shortest limit.
        set_age_limit(32'd1);
        queue_request(arpc_pkg::FUNC_UPDATE, ip_pool[2], 48'h0000_0000_0001, 48'd100);
        queue_request(arpc_pkg::FUNC_LOOKUP, ip_pool[2], '0, 48'd101);
        queue_request(arpc_pkg::FUNC_LOOKUP, ip_pool[2], '0, 48'd102);
        clock_ms = 64'd200;
        queue_random(250, 40);
        wait_drained();

        // Longest limit.
        set_age_limit('1);
        queue_request(arpc_pkg::FUNC_UPDATE, ip_pool[3], 48'h8000_0000_0000, 48'd1000);
        queue_request(arpc_pkg::FUNC_LOOKUP, ip_pool[3], '0, 48'd1000 + 48'hFFFF_FFFF);
        queue_request(arpc_pkg::FUNC_LOOKUP, ip_pool[3], '0, 48'd1000 + 48'h1_0000_0000);
        clock_ms = 64'h1_0000_1000;
        queue_random(250, POOL_SIZE);
        wait_drained();

        // Mid-range limit, random time base, one long result stall.
        set_age_limit(32'd5000);
        clock_ms = {16'b0, 16'($urandom), 32'($urandom)};
        queue_random(250, POOL_SIZE);
        holds_asked++;
        wait_drained();
        queue_random(250, POOL_SIZE);
        wait_drained();

        // Reset value written back, no idling on either side.
        set_age_limit(arpc_pkg::MAX_AGE_RESET);
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        clock_ms = 64'd1;
        queue_random(450, 72);
        wait_drained();

        // Random limit, time base near the top so that it wraps.
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        set_age_limit(arpc_pkg::AGE_W'($urandom_range(1, 32'hFFFF_FFFF)));
        clock_ms = 64'h0000_FFFF_FFF0_0000;
        queue_random(475, POOL_SIZE);
        wait_drained();

        // Let any stray result show up before the verdict.
        repeat (2 * CACHE_DEPTH + 16) @(posedge i_clk);
        if (answer_q.size() != 0)
            flag_error($sformatf("%0d predicted results never arrived", answer_q.size()));

        $display("Sent %0d requests under %0d stale limits; checked %0d results.",
                 n_sent, n_limits + 1, n_checked);
        $display("Lookups: %0d hits, %0d stale, %0d misses; updates: %0d; errors: %0d.",
                 n_hit, n_stale, n_miss, n_update, err_cnt);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
